>>> rtl/plu_pkg.sv
// ----------------------------------------------------------------------------
// plu_pkg
// Shared widths and constants for the PCM linear interpolation upsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package plu_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAX_FACTOR = 16;
  localparam int FACTOR_W   = $clog2(MAX_FACTOR + 1);
  localparam int CFG_FACT_W = 5;
  localparam int BIT_CNT_W  = $clog2(SAMPLE_W);
  // numerator quotient track: sample width plus sign and carry headroom
  localparam int ACC_W      = SAMPLE_W + 2;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [APB_ADDR_W-3:0] REG_UP_FACTOR = '0;
  localparam logic [CFG_FACT_W-1:0] UP_FACTOR_RST = CFG_FACT_W'(2);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

>>> rtl/plu_in_if.sv
// ----------------------------------------------------------------------------
// plu_in_if
// Input sample channel: valid/ready with the PCM sample and frame marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface plu_in_if import plu_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t in_sample;
  logic    frame_last;

  modport source (output valid, output in_sample, output frame_last, input ready);
  modport sink   (input valid, input in_sample, input frame_last, output ready);
endinterface

`default_nettype wire

>>> rtl/plu_out_if.sv
// ----------------------------------------------------------------------------
// plu_out_if
// Result channel: valid/ready with the interpolated sample and run flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface plu_out_if import plu_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_sample;
  logic    run_last;
  logic    frame_end;

  modport source (output valid, output out_sample, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input out_sample, input run_last, input frame_end,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/pcm_linear_interp_upsampler.sv
// ----------------------------------------------------------------------------
// pcm_linear_interp_upsampler
// Linear interpolation integer upsampler for signed 16-bit PCM.
// ----------------------------------------------------------------------------
// Each accepted sample produces M output beats on the line from the previous
// sample to the new one, result j = trunc((prev*M + (new-prev)*j) / M), the
// last one equal to the new sample and flagged run_last (and frame_end when
// the input carried frame_last). M is up_factor at APB offset 0 (reset 2,
// 0 acts as 1, values above 16 saturate). The step (new-prev)/M is found by
// a one-bit-per-cycle restoring divider, then a sign fixup state, then the
// emit state walks quotient and remainder, loading one beat into the output
// register whenever it is free or being taken, and holding while the output
// is stalled. The input is not ready while an item is in work; the output
// has its own beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_linear_interp_upsampler import plu_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  plu_in_if.sink                     in_bus,
  plu_out_if.source                  out_bus,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic      [APB_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CFG_FACT_W-1:0]   up_factor_r, up_factor_nxt;
  sample_t                 prev_r, prev_nxt;
  logic [FACTOR_W-1:0]     m_r, m_nxt;
  logic                    last_r, last_nxt;
  logic                    neg_r, neg_nxt;
  logic [SAMPLE_W-1:0]     quo_r, quo_nxt;
  logic [FACTOR_W-1:0]     rem_r, rem_nxt;
  logic [BIT_CNT_W-1:0]    bit_r, bit_nxt;
  logic [ACC_W-1:0]        q_r, q_nxt;
  logic [FACTOR_W-1:0]     r_r, r_nxt;
  logic [ACC_W-1:0]        qd_r, qd_nxt;
  logic [FACTOR_W-1:0]     rd_r, rd_nxt;
  logic [FACTOR_W-1:0]     cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]     out_sample_r, out_sample_nxt;
  logic                    out_run_last_r, out_run_last_nxt;
  logic                    out_frame_end_r, out_frame_end_nxt;

  logic                    in_fire;
  logic                    cfg_wr;
  logic [FACTOR_W-1:0]     m_eff;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]       diff_mag;
  logic [FACTOR_W:0]       rem_sh;
  logic                    rem_ge;
  logic [ACC_W-1:0]        quo_ext;
  logic [FACTOR_W:0]       r_sum;
  logic                    carry;
  logic [FACTOR_W-1:0]     r_step;
  logic [ACC_W-1:0]        q_step;
  logic [ACC_W-1:0]        q_trunc;
  logic                    emit_load;
  logic                    emit_final;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign cfg_pready    = 1'b1;
  assign cfg_wr        = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                         (cfg_paddr[APB_ADDR_W-1:2] == REG_UP_FACTOR);
  assign cfg_prdata    = (cfg_paddr[APB_ADDR_W-1:2] == REG_UP_FACTOR) ?
                         APB_DATA_W'(up_factor_r) : '0;

  assign out_bus.valid      = out_valid_r;
  assign out_bus.out_sample = out_sample_r;
  assign out_bus.run_last   = out_run_last_r;
  assign out_bus.frame_end  = out_frame_end_r;

  always_comb begin
    if (up_factor_r == '0) begin
      m_eff = FACTOR_W'(1);
    end else if (int'(up_factor_r) > MAX_FACTOR) begin
      m_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      m_eff = FACTOR_W'(up_factor_r);
    end
  end

  assign diff     = {in_bus.in_sample[SAMPLE_W-1], in_bus.in_sample} -
                    {prev_r[SAMPLE_W-1], prev_r};
  assign diff_mag = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

  // restoring divide step on |diff| / M
  assign rem_sh  = {rem_r, quo_r[SAMPLE_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, m_r});
  assign quo_ext = {{(ACC_W-SAMPLE_W){1'b0}}, quo_r};

  // walk numerator quotient/remainder by one step of diff
  assign r_sum      = {1'b0, r_r} + {1'b0, rd_r};
  assign carry      = (r_sum >= {1'b0, m_r});
  assign r_step     = carry ? FACTOR_W'(r_sum - {1'b0, m_r}) : r_sum[FACTOR_W-1:0];
  assign q_step     = q_r + qd_r + {{(ACC_W-1){1'b0}}, carry};
  // floor to truncation toward zero
  assign q_trunc    = q_step + {{(ACC_W-1){1'b0}}, (q_step[ACC_W-1] && (r_step != '0))};
  assign emit_load  = (state_r == ST_EMIT) && (!out_valid_r || out_bus.ready);
  assign emit_final = (cnt_r == m_r);

  always_comb begin
    state_nxt         = state_r;
    up_factor_nxt     = up_factor_r;
    prev_nxt          = prev_r;
    m_nxt             = m_r;
    last_nxt          = last_r;
    neg_nxt           = neg_r;
    quo_nxt           = quo_r;
    rem_nxt           = rem_r;
    bit_nxt           = bit_r;
    q_nxt             = q_r;
    r_nxt             = r_r;
    qd_nxt            = qd_r;
    rd_nxt            = rd_r;
    cnt_nxt           = cnt_r;
    out_valid_nxt     = out_valid_r && !out_bus.ready;
    out_sample_nxt    = out_sample_r;
    out_run_last_nxt  = out_run_last_r;
    out_frame_end_nxt = out_frame_end_r;

    if (cfg_wr) begin
      up_factor_nxt = cfg_pwdata[CFG_FACT_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          m_nxt     = m_eff;
          last_nxt  = in_bus.frame_last;
          neg_nxt   = diff[SAMPLE_W];
          quo_nxt   = diff_mag[SAMPLE_W-1:0];
          rem_nxt   = '0;
          bit_nxt   = '0;
          q_nxt     = ACC_W'(signed'(prev_r));
          r_nxt     = '0;
          cnt_nxt   = FACTOR_W'(1);
          prev_nxt  = in_bus.in_sample;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? FACTOR_W'(rem_sh - {1'b0, m_r}) : rem_sh[FACTOR_W-1:0];
        quo_nxt = {quo_r[SAMPLE_W-2:0], rem_ge};
        bit_nxt = bit_r + 1'b1;
        if (bit_r == BIT_CNT_W'(SAMPLE_W - 1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        // floor division for a negative step
        if (!neg_r) begin
          qd_nxt = quo_ext;
          rd_nxt = rem_r;
        end else if (rem_r == '0) begin
          qd_nxt = ~quo_ext + 1'b1;
          rd_nxt = '0;
        end else begin
          qd_nxt = ~quo_ext;
          rd_nxt = m_r - rem_r;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load) begin
          q_nxt             = q_step;
          r_nxt             = r_step;
          out_valid_nxt     = 1'b1;
          out_sample_nxt    = q_trunc[SAMPLE_W-1:0];
          out_run_last_nxt  = emit_final;
          out_frame_end_nxt = emit_final && last_r;
          cnt_nxt           = cnt_r + 1'b1;
          if (emit_final) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      up_factor_r <= UP_FACTOR_RST;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      up_factor_r <= up_factor_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r             <= m_nxt;
    last_r          <= last_nxt;
    neg_r           <= neg_nxt;
    quo_r           <= quo_nxt;
    rem_r           <= rem_nxt;
    bit_r           <= bit_nxt;
    q_r             <= q_nxt;
    r_r             <= r_nxt;
    qd_r            <= qd_nxt;
    rd_r            <= rd_nxt;
    cnt_r           <= cnt_nxt;
    out_sample_r    <= out_sample_nxt;
    out_run_last_r  <= out_run_last_nxt;
    out_frame_end_r <= out_frame_end_nxt;
  end

  // an accepted beat always starts the divider
  a_fire_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_DIV))
    else $error("accepted sample did not start division");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < m_r))
    else $error("divider remainder out of range");

  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ((cnt_r != '0) && (cnt_r <= m_r) && (r_r < m_r)))
    else $error("emit counter or remainder out of range");

  a_frame_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end_r) |-> out_run_last_r)
    else $error("frame_end without run_last");

  // final beat of a run matches the sample that caused it
  a_last_is_new: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && emit_final) |=> (out_sample_r == prev_r))
    else $error("last interpolated beat differs from new sample");

endmodule

`default_nettype wire
